// File: sv/bcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Types, codes and defaults shared by the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int KEY_W        = 2;
  localparam int CODE_W       = 3;
  localparam int TICK_W       = 16;
  localparam int CNT_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd30;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd150;
  localparam logic [TICK_W-1:0] MAX_TICKS_RST   = 16'd255;
  localparam logic [CNT_W-1:0]  CLICKS_TRIPLE   = 2'd3;
  localparam logic [CNT_W-1:0]  CLICKS_DOUBLE   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_TICKS = 2'd0,
    CFG_LONG_TICKS  = 2'd1,
    CFG_MAX_TICKS   = 2'd2,
    CFG_TRIPLE_UD   = 2'd3
  } cfg_index_t;

  typedef enum logic [CODE_W-1:0] {
    EV_SINGLE   = 3'd0,
    EV_DOUBLE   = 3'd1,
    EV_TRIPLE   = 3'd2,
    EV_LONG     = 3'd3,
    EV_PRESSED  = 3'd4,
    EV_RELEASED = 3'd5
  } event_code_t;

  typedef struct packed {
    logic              last_level;
    logic              updown_mode;
    logic              release_guard;
    logic [CNT_W-1:0]  click_count;
    logic [TICK_W-1:0] hold_ticks;
  } key_state_t;

  typedef struct packed {
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] max_ticks;
    logic              triple_enters_updown;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             new_mode;
    logic             guard_arg;
  } item_t;

endpackage
`default_nettype wire

// File: sv/bcc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_in_if / bcc_out_if
// Valid-ready channels for sample words and event words.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [bcc_pkg::KEY_W-1:0] key;
  logic                     pressed;
  logic                     new_mode;
  logic                     guard_arg;

  modport source (output valid, mode, key, pressed, new_mode, guard_arg, input ready);
  modport sink   (input valid, mode, key, pressed, new_mode, guard_arg, output ready);
endinterface

interface bcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [bcc_pkg::KEY_W-1:0]  event_key;
  logic [bcc_pkg::CODE_W-1:0] event_code;

  modport source (output valid, event_key, event_code, input ready);
  modport sink   (input valid, event_key, event_code, output ready);
endinterface
`default_nettype wire

// File: sv/button_click_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Per-key click, long-press and up-down classifier.
// ----------------------------------------------------------------------------
// One word per clock is taken unless the input register is stalled. A word is
// registered, then classified against the key's state in the next cycle, which
// writes the key state and the event register in one read-modify-write. The
// event word passes from the input register into the event register. Words
// that cause no event drain without touching the event register. Sustained
// rate is one word per cycle unless a word that raises an event waits in the
// input register, holding off new input, while the sink has not yet taken the
// previous event word. The user must write configuration only while the block
// is idle, via cfg_we/cfg_index/cfg_wdata; the block does not enforce this.
module button_click_classifier_top #(
  parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bcc_in_if.sink                                 in_ch,
  bcc_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bcc_pkg::cfg_t       cfg;
  bcc_pkg::key_state_t keys [NUM_KEYS];
  bcc_pkg::item_t      s1_item;
  logic                s1_valid;
  logic                s1_go;
  logic                key_ok;
  bcc_pkg::key_state_t cur;
  bcc_pkg::key_state_t nxt;
  logic                cls_event;
  bcc_pkg::event_code_t cls_code;
  logic                has_event;
  logic                out_valid;
  logic [bcc_pkg::KEY_W-1:0]  out_key;
  bcc_pkg::event_code_t       out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ticks          <= bcc_pkg::SHORT_TICKS_RST;
      cfg.long_ticks           <= bcc_pkg::LONG_TICKS_RST;
      cfg.max_ticks            <= bcc_pkg::MAX_TICKS_RST;
      cfg.triple_enters_updown <= 1'b0;
    end else if (cfg_we) begin
      unique case (bcc_pkg::cfg_index_t'(cfg_index))
        bcc_pkg::CFG_SHORT_TICKS: cfg.short_ticks          <= cfg_wdata;
        bcc_pkg::CFG_LONG_TICKS:  cfg.long_ticks           <= cfg_wdata;
        bcc_pkg::CFG_MAX_TICKS:   cfg.max_ticks            <= cfg_wdata;
        bcc_pkg::CFG_TRIPLE_UD:   cfg.triple_enters_updown <= cfg_wdata[0];
      endcase
    end
  end

  assign key_ok = 32'(s1_item.key) < NUM_KEYS;

  always_comb begin
    cur = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(s1_item.key) == k) begin
        cur = keys[k];
      end
    end
  end

  bcc_classify u_classify (
    .item      (s1_item),
    .cur       (cur),
    .cfg       (cfg),
    .nxt       (nxt),
    .has_event (cls_event),
    .code      (cls_code)
  );

  assign has_event   = cls_event && key_ok;
  assign s1_go       = s1_valid && (!has_event || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item.mode      <= in_ch.mode;
      s1_item.key       <= in_ch.key;
      s1_item.pressed   <= in_ch.pressed;
      s1_item.new_mode  <= in_ch.new_mode;
      s1_item.guard_arg <= in_ch.guard_arg;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (rst) begin
        keys[k] <= '0;
      end else if (s1_go && 32'(s1_item.key) == k) begin
        keys[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_event) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_event) begin
      out_key  <= s1_item.key;
      out_code <= cls_code;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.event_key  = out_key;
  assign out_ch.event_code = out_code;

  a_released_from_updown: assert property (@(posedge clk) disable iff (rst)
    (s1_go && has_event && cls_code == bcc_pkg::EV_RELEASED) |-> cur.updown_mode)
    else $error("released event from a key in click mode");

  a_pressed_held: assert property (@(posedge clk) disable iff (rst)
    (s1_go && has_event && cls_code == bcc_pkg::EV_PRESSED)
      |-> (cur.updown_mode && s1_item.pressed))
    else $error("pressed event without a held up-down key");

  a_silent_words: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_item.mode || !key_ok)) |-> !has_event)
    else $error("event from a set-mode word or an absent key");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_item)))
    else $error("stalled word lost from the input register");

  a_event_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_go && has_event) |=> (out_valid && out_key == $past(s1_item.key)))
    else $error("event word not loaded into the output register");

endmodule
`default_nettype wire

// File: sv/bcc_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_classify
// Next state and event of one key for one sample or set-mode word.
// ----------------------------------------------------------------------------
module bcc_classify (
  input  var bcc_pkg::item_t      item,
  input  var bcc_pkg::key_state_t cur,
  input  var bcc_pkg::cfg_t       cfg,
  output bcc_pkg::key_state_t     nxt,
  output logic                    has_event,
  output bcc_pkg::event_code_t    code
);

  always_comb begin
    nxt       = cur;
    has_event = 1'b0;
    code      = bcc_pkg::EV_SINGLE;
    if (item.mode) begin
      nxt.last_level    = 1'b0;
      nxt.release_guard = ~item.guard_arg;
      nxt.click_count   = '0;
      nxt.hold_ticks    = '0;
      nxt.updown_mode   = item.new_mode;
    end else if (cur.updown_mode) begin
      if (item.pressed) begin
        has_event = 1'b1;
        code      = bcc_pkg::EV_PRESSED;
      end else if (cur.last_level) begin
        nxt       = '0;
        has_event = 1'b1;
        code      = bcc_pkg::EV_RELEASED;
      end
      nxt.last_level = item.pressed;
    end else begin
      if (cur.last_level != item.pressed) begin
        nxt.hold_ticks = 16'd1;
        if (!item.pressed) begin
          if (cur.release_guard) begin
            nxt.release_guard = 1'b0;
            nxt.hold_ticks    = '0;
          end else begin
            nxt.click_count = cur.click_count + 2'd1;
          end
        end
      end else if (cur.hold_ticks != '0 && cur.hold_ticks < cfg.max_ticks) begin
        nxt.hold_ticks = cur.hold_ticks + 16'd1;
      end

      priority if (nxt.click_count == bcc_pkg::CLICKS_TRIPLE) begin
        has_event       = 1'b1;
        code            = bcc_pkg::EV_TRIPLE;
        nxt.click_count = '0;
        nxt.hold_ticks  = '0;
        if (cfg.triple_enters_updown) begin
          nxt.release_guard = 1'b0;
          nxt.updown_mode   = 1'b1;
        end
      end else if (nxt.hold_ticks > cfg.short_ticks && !item.pressed) begin
        has_event = 1'b1;
        code      = (nxt.click_count == bcc_pkg::CLICKS_DOUBLE) ? bcc_pkg::EV_DOUBLE
                                                               : bcc_pkg::EV_SINGLE;
        nxt.click_count = '0;
        nxt.hold_ticks  = '0;
      end else if (nxt.hold_ticks > cfg.long_ticks && item.pressed) begin
        has_event         = 1'b1;
        code              = bcc_pkg::EV_LONG;
        nxt.click_count   = '0;
        nxt.hold_ticks    = '0;
        nxt.release_guard = 1'b1;
      end else begin
        has_event = 1'b0;
      end
      nxt.last_level = item.pressed;
    end
  end

endmodule
`default_nettype wire
